>>> rtl/see_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the stack expression evaluator.
// No dependencies; used by see_ram and stack_expression_evaluator_top.
package see_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int DATA_W          = 64;
  localparam int HALF_W          = DATA_W / 2;
  localparam int FUNC_W          = 3;
  localparam int DEPTH_W         = 5;
  localparam int STATUS_W        = 2;
  localparam int IN_TDATA_W      = DATA_W;
  localparam int OUT_TDATA_W     = ((DATA_W + DEPTH_W + 7) / 8) * 8;
  localparam int DIV_STEPS       = DATA_W;
  localparam int CNT_W           = $clog2(DIV_STEPS);

  typedef enum logic [FUNC_W-1:0] {
    FN_LOAD  = 3'd0,
    FN_ADD   = 3'd1,
    FN_SUB   = 3'd2,
    FN_MUL   = 3'd3,
    FN_DIV   = 3'd4,
    FN_CLEAR = 3'd5,
    FN_TAKE  = 3'd6
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_DIVZERO   = 2'd3
  } status_t;

endpackage

>>> rtl/see_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Depends on see_pkg for default sizes.
module see_ram
  import see_pkg::*;
#(
  parameter int WIDTH = DATA_W,
  parameter int DEPTH = STACK_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/stack_expression_evaluator_top.sv
`timescale 1ns / 1ps
// Stack-machine integer ALU: command sequencer, shared multiplier, serial divider.
// Depends on see_pkg and see_ram (operand stack storage).
//
// Usage:
//   Input stream: s_tuser carries the command, s_tdata the 64-bit constant.
//   Output stream: one transfer per command with the top value, depth, status.
//   One command is in flight at a time; s_tready is high while the sequencer
//   waits for a command. The stack lives in a RAM with a registered read;
//   the top entry is fetched at the accepting edge, the second from S_RDA.
//   Load, clear, take and unused codes go from S_RDA to the output; add
//   and subtract compute in S_RDB; multiply forms three 32x32 partial
//   products on one multiplier; divide is a restoring divider, one
//   quotient bit a cycle.
//   Errors report status and leave the stack as it was.
//   Reset (rst, synchronous) empties the stack and drops any pending result;
//   RAM contents are not cleared, and no entry above the pointer is read.
//   When the receiver stalls, the result holds in the output register and
//   the next command may still be accepted and run until its own result
//   is ready; it then waits for the register to free up.
module stack_expression_evaluator_top
  import see_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,  // [63:0] operand_value
  input  logic [FUNC_W-1:0]      s_tuser,  // [2:0] func
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,  // [63:0] top_value, [68:64] stack_depth
  output logic [STATUS_W-1:0]    m_tuser   // [1:0] status
);

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int PAD = OUT_TDATA_W - DATA_W - DEPTH_W;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RDA  = 7'b0000010,
    S_RDB  = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_WB   = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t             state;
  logic [SPW-1:0]     sp;
  func_t              func_q;
  logic [DATA_W-1:0]  value_q;
  logic [DATA_W-1:0]  opa;
  logic [DATA_W-1:0]  opb;
  logic [DATA_W-1:0]  r;
  logic [DATA_W-1:0]  rem;
  logic [DATA_W-1:0]  prod;
  logic [CNT_W-1:0]   cnt;
  logic [DATA_W-1:0]  res_top;
  status_t            res_status;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [DATA_W-1:0]  ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [DATA_W-1:0]  ram_rdata;

  logic [HALF_W-1:0]  mul_x;
  logic [HALF_W-1:0]  mul_y;
  logic [DATA_W:0]    trial;
  logic [SPW-1:0]     sp_m1;
  logic [SPW-1:0]     sp_m2;
  logic               sp_full;
  logic               sp_empty;
  logic               out_free;
  logic [DATA_W-1:0]  cur_top;

  assign sp_m1    = sp - SPW'(1);
  assign sp_m2    = sp - SPW'(2);
  assign sp_full  = (sp == SPW'(STACK_DEPTH));
  assign sp_empty = (sp == '0);
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);
  // rdata in S_RDA is the entry at sp-1, fetched at the accept edge
  assign cur_top  = sp_empty ? '0 : ram_rdata;

  // Top is fetched while idle, second entry from S_RDA. Every write lands
  // before the next command's fetch, so no forwarding path is needed.
  assign ram_raddr = (state == S_RDA) ? sp_m2[AW-1:0] : sp_m1[AW-1:0];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sp[AW-1:0];
    ram_wdata = value_q;
    if (state == S_RDA && func_q == FN_LOAD && !sp_full) begin
      ram_we = 1'b1;
    end else if (state == S_WB) begin
      ram_we    = 1'b1;
      ram_waddr = sp_m2[AW-1:0];
      ram_wdata = r;
    end
  end

  see_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // partial products: step 0 aL*bL, step 1 aL*bH, step 2 aH*bL
  assign mul_x = (cnt[1:0] == 2'd2) ? opa[DATA_W-1:HALF_W] : opa[HALF_W-1:0];
  assign mul_y = (cnt[1:0] == 2'd1) ? opb[DATA_W-1:HALF_W] : opb[HALF_W-1:0];

  assign trial = {rem, r[DATA_W-1]} - {1'b0, opa};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      sp       <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // S_OUT reloads the register itself when it is free
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            func_q  <= func_t'(s_tuser);
            value_q <= s_tdata;
            state   <= S_RDA;
          end
        end
        S_RDA: begin
          res_status <= ST_OK;
          res_top    <= cur_top;
          opa        <= ram_rdata;
          state      <= S_OUT;
          unique case (func_q)
            FN_LOAD: begin
              if (sp_full) begin
                res_status <= ST_OVERFLOW;
              end else begin
                sp      <= sp + SPW'(1);
                res_top <= value_q;
              end
            end
            FN_ADD, FN_SUB, FN_MUL, FN_DIV: begin
              if (sp < SPW'(2)) begin
                res_status <= ST_UNDERFLOW;
              end else begin
                state <= S_RDB;
              end
            end
            FN_CLEAR: begin
              sp      <= '0;
              res_top <= '0;
            end
            FN_TAKE: begin
              if (sp_empty) begin
                res_status <= ST_UNDERFLOW;
              end else begin
                sp <= sp_m1;
              end
            end
            default: begin
              // unused code: report current top and depth
            end
          endcase
        end
        S_RDB: begin
          opb <= ram_rdata;
          cnt <= '0;
          unique case (func_q)
            FN_ADD: begin
              r     <= ram_rdata + opa;
              state <= S_WB;
            end
            FN_SUB: begin
              r     <= ram_rdata - opa;
              state <= S_WB;
            end
            FN_MUL: begin
              state <= S_MUL;
            end
            default: begin
              if (opa == '0) begin
                res_status <= ST_DIVZERO;
                state      <= S_OUT;
              end else begin
                r     <= ram_rdata;
                rem   <= '0;
                state <= S_DIV;
              end
            end
          endcase
        end
        S_MUL: begin
          prod <= DATA_W'(mul_x) * DATA_W'(mul_y);
          cnt  <= cnt + CNT_W'(1);
          unique case (cnt[1:0])
            2'd0: begin
            end
            2'd1: begin
              r <= prod;
            end
            2'd2: begin
              r <= r + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
            end
            default: begin
              r     <= r + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
              state <= S_WB;
            end
          endcase
        end
        S_DIV: begin
          // restoring step: shift in next dividend bit, subtract if it fits
          if (!trial[DATA_W]) begin
            rem <= trial[DATA_W-1:0];
            r   <= {r[DATA_W-2:0], 1'b1};
          end else begin
            rem <= {rem[DATA_W-2:0], r[DATA_W-1]};
            r   <= {r[DATA_W-2:0], 1'b0};
          end
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(DIV_STEPS - 1)) begin
            state <= S_WB;
          end
        end
        S_WB: begin
          sp         <= sp_m1;
          res_top    <= r;
          res_status <= ST_OK;
          state      <= S_OUT;
        end
        S_OUT: begin
          // hold until the output register is free
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {{PAD{1'b0}}, DEPTH_W'(sp), res_top};
            m_tuser  <= res_status;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= SPW'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_accept_fetch: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_RDA))
    else $error("accepted command did not start a fetch");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_OVERFLOW) |->
      (m_tdata[DATA_W +: DEPTH_W] == DEPTH_W'(STACK_DEPTH)))
    else $error("overflow reported on a stack that is not full");

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_RDA || state == S_WB))
    else $error("stack write outside a command");

endmodule
